/* design/first_fit_free_list_allocator_macros.svh */
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_macros.svh
// Assertion shorthands shared by the allocator RTL. The including module
// must have aclk and aresetn in scope.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH

// Condition must hold at every clock edge out of reset
`define FFA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// When trig holds, cond must hold in the next cycle
`define FFA_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* design/ffa_pkg.sv */
// ----------------------------------------------------------------------------
// ffa_pkg
// Types and fixed constants of the first-fit free-list allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

    // Address space and block geometry
    localparam int ADDR_BITS    = 16;
    localparam int ALIGN_BYTES  = 4;
    localparam int HEADER_BYTES = 4;
    localparam int ALIGN_SHIFT  = $clog2(ALIGN_BYTES);
    localparam int SLOT_COUNT   = 16384;
    localparam int SLOT_BITS    = $clog2(SLOT_COUNT);
    localparam int NEED_BITS    = ADDR_BITS + 1;

    // Configuration registers
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HEAP_START = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HEAP_END   = 1'd1;
    localparam logic [ADDR_BITS-1:0] HEAP_START_RESET = 16'h0000;
    localparam logic [ADDR_BITS-1:0] HEAP_END_RESET   = 16'hFFFF;

    // Request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [SLOT_BITS-1:0] slot_t;

    typedef struct packed {
        logic  opcode;
        addr_t req_size;
        addr_t free_addr;
    } in_word_t;

    typedef struct packed {
        addr_t addr;
        logic  ok;
    } out_word_t;

    // Header address to header-store slot
    function automatic slot_t slot_of(addr_t hdr);
        addr_t sh;
        sh = hdr >> ALIGN_SHIFT;
        return sh[SLOT_BITS-1:0];
    endfunction

endpackage

/* design/ffa_ram.sv */
// ----------------------------------------------------------------------------
// ffa_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ffa_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/first_fit_free_list_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator
// First-fit heap allocator with a LIFO free list kept in header RAMs.
// ----------------------------------------------------------------------------
// One request word is handled at a time. A free, a null free or an allocate
// whose rounded size overflows goes straight to the result state, which loads
// its result word into the output register once that register is free. An
// allocate first walks the free list, visiting headers in list order, and
// falls back to bumping the top pointer when the walk finds no fit; the walk reads one
// header per cycle through the read port of the size and link RAMs, each read
// address coming from the link just read. The next request is accepted in the
// cycle after the result is loaded, even if that result is still waiting for
// m_ready. A result waits in its holding register while the output register
// is full. Header RAMs need no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "first_fit_free_list_allocator_macros.svh"

module first_fit_free_list_allocator (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // request channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  ffa_pkg::in_word_t                     s_word,
    // result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output ffa_pkg::out_word_t                    m_word,
    // configuration write port
    input  logic                                  cfg_we,
    input  logic [ffa_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [ffa_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_BUMP,
        ST_RESP
    } state_t;

    state_t                    state_reg, state_next;
    ffa_pkg::addr_t            heap_end_reg, heap_end_next;
    ffa_pkg::addr_t            top_reg, top_next;
    ffa_pkg::addr_t            free_head_reg, free_head_next;
    ffa_pkg::addr_t            need_reg, need_next;
    ffa_pkg::addr_t            cur_reg, cur_next;
    ffa_pkg::addr_t            prev_reg, prev_next;
    logic                      prev_is_head_reg, prev_is_head_next;
    ffa_pkg::slot_t            steps_reg, steps_next;
    ffa_pkg::out_word_t        res_reg, res_next;
    logic                      m_valid_reg, m_valid_next;
    ffa_pkg::out_word_t        m_word_reg, m_word_next;

    // RAM ports
    logic                      size_we;
    ffa_pkg::slot_t            size_waddr;
    ffa_pkg::addr_t            size_wdata;
    ffa_pkg::addr_t            size_rdata;
    logic                      link_we;
    ffa_pkg::slot_t            link_waddr;
    ffa_pkg::addr_t            link_wdata;
    ffa_pkg::addr_t            link_rdata;
    ffa_pkg::slot_t            rd_slot;

    // Datapath helpers
    logic [ffa_pkg::NEED_BITS-1:0] need_sum;
    logic [ffa_pkg::NEED_BITS-1:0] need_rnd;
    logic [ffa_pkg::NEED_BITS-1:0] top_sum;
    logic                          bump_fits;
    logic                          fit;
    ffa_pkg::addr_t                free_hdr;

    // Header stores: block size and next link per slot
    ffa_ram #(
        .DATA_W (ffa_pkg::ADDR_BITS),
        .DEPTH  (ffa_pkg::SLOT_COUNT)
    ) u_size_ram (
        .aclk  (aclk),
        .we    (size_we),
        .waddr (size_waddr),
        .wdata (size_wdata),
        .raddr (rd_slot),
        .rdata (size_rdata)
    );

    ffa_ram #(
        .DATA_W (ffa_pkg::ADDR_BITS),
        .DEPTH  (ffa_pkg::SLOT_COUNT)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (rd_slot),
        .rdata (link_rdata)
    );

    // Size rounding, header address of a free, bump check
    always_comb begin
        need_sum  = ffa_pkg::NEED_BITS'(s_word.req_size)
                  + ffa_pkg::NEED_BITS'(ffa_pkg::HEADER_BYTES + ffa_pkg::ALIGN_BYTES - 1);
        need_rnd  = (need_sum >> ffa_pkg::ALIGN_SHIFT) << ffa_pkg::ALIGN_SHIFT;
        free_hdr  = s_word.free_addr - ffa_pkg::ADDR_BITS'(ffa_pkg::HEADER_BYTES);
        top_sum   = {1'b0, top_reg} + {1'b0, need_reg};
        bump_fits = top_sum < {1'b0, heap_end_reg};
        fit       = size_rdata >= need_reg;
    end

    // Header read address: list head at start, then the link just read
    assign rd_slot = (state_reg == ST_IDLE) ? ffa_pkg::slot_of(free_head_reg)
                                            : ffa_pkg::slot_of(link_rdata);

    assign s_ready = (state_reg == ST_IDLE);

    // Next-state and datapath control
    always_comb begin
        state_next        = state_reg;
        heap_end_next     = heap_end_reg;
        top_next          = top_reg;
        free_head_next    = free_head_reg;
        need_next         = need_reg;
        cur_next          = cur_reg;
        prev_next         = prev_reg;
        prev_is_head_next = prev_is_head_reg;
        steps_next        = steps_reg;
        res_next          = res_reg;
        m_valid_next      = m_valid_reg;
        m_word_next       = m_word_reg;
        size_we           = 1'b0;
        size_waddr        = ffa_pkg::slot_of(top_reg);
        size_wdata        = need_reg;
        link_we           = 1'b0;
        link_waddr        = ffa_pkg::slot_of(top_reg);
        link_wdata        = '0;

        // output register drains
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_word.opcode == ffa_pkg::OP_FREE) begin
                        // push onto list head; null free does nothing
                        if (s_word.free_addr != '0) begin
                            link_we        = 1'b1;
                            link_waddr     = ffa_pkg::slot_of(free_hdr);
                            link_wdata     = free_head_reg;
                            free_head_next = free_hdr;
                        end
                        res_next   = '{addr: '0, ok: 1'b1};
                        state_next = ST_RESP;
                    end else begin
                        need_next = need_rnd[ffa_pkg::ADDR_BITS-1:0];
                        if (need_rnd[ffa_pkg::ADDR_BITS]) begin
                            // rounded size beyond address range
                            res_next   = '{addr: '0, ok: 1'b0};
                            state_next = ST_RESP;
                        end else if (free_head_reg == '0) begin
                            state_next = ST_BUMP;
                        end else begin
                            cur_next          = free_head_reg;
                            prev_is_head_next = 1'b1;
                            steps_next        = '0;
                            state_next        = ST_WALK;
                        end
                    end
                end
            end

            ST_WALK: begin
                if (fit) begin
                    // unlink the current block
                    if (prev_is_head_reg) begin
                        free_head_next = link_rdata;
                    end else begin
                        link_we    = 1'b1;
                        link_waddr = ffa_pkg::slot_of(prev_reg);
                        link_wdata = link_rdata;
                    end
                    res_next   = '{addr: cur_reg + ffa_pkg::ADDR_BITS'(ffa_pkg::HEADER_BYTES),
                                   ok: 1'b1};
                    state_next = ST_RESP;
                end else begin
                    prev_next         = cur_reg;
                    prev_is_head_next = 1'b0;
                    cur_next          = link_rdata;
                    steps_next        = steps_reg + 1'b1;
                    // walk bounded to one visit per slot
                    if (link_rdata == '0 ||
                        steps_reg == ffa_pkg::SLOT_BITS'(ffa_pkg::SLOT_COUNT - 1)) begin
                        state_next = ST_BUMP;
                    end
                end
            end

            ST_BUMP: begin
                if (bump_fits) begin
                    size_we    = 1'b1;
                    link_we    = 1'b1;
                    top_next   = top_sum[ffa_pkg::ADDR_BITS-1:0];
                    res_next   = '{addr: top_reg + ffa_pkg::ADDR_BITS'(ffa_pkg::HEADER_BYTES),
                                   ok: 1'b1};
                end else begin
                    res_next   = '{addr: '0, ok: 1'b0};
                end
                state_next = ST_RESP;
            end

            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_word_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // configuration writes, expected only while idle
        if (cfg_we) begin
            unique case (cfg_index)
                ffa_pkg::CFG_HEAP_START: top_next      = cfg_wdata;
                ffa_pkg::CFG_HEAP_END:   heap_end_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            heap_end_reg  <= ffa_pkg::HEAP_END_RESET;
            top_reg       <= ffa_pkg::HEAP_START_RESET;
            free_head_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            heap_end_reg  <= heap_end_next;
            top_reg       <= top_next;
            free_head_reg <= free_head_next;
            m_valid_reg   <= m_valid_next;
        end
        need_reg         <= need_next;
        cur_reg          <= cur_next;
        prev_reg         <= prev_next;
        prev_is_head_reg <= prev_is_head_next;
        steps_reg        <= steps_next;
        res_reg          <= res_next;
        m_word_reg       <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    // Checks
    `FFA_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready,
        "request accepted while busy")
    `FFA_ASSERT_NEXT(a_resp_loads, state_reg == ST_RESP && (!m_valid_reg || m_ready),
        m_valid_reg && state_reg == ST_IDLE, "result not loaded")
    `FFA_ASSERT_ALWAYS(a_fail_null,
        !m_valid_reg || m_word_reg.ok || m_word_reg.addr == '0,
        "failed result with nonzero address")
    `FFA_ASSERT_NEXT(a_top_below_end, state_reg == ST_BUMP && bump_fits && !cfg_we,
        top_reg < heap_end_reg, "top pointer reached heap end")

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - first-fit free-list allocator testbench
// Drives allocate and free words over the request channel under several heap
// settings, predicts each result word from a private copy of the heap state
// (top pointer, list head, header store), and checks results in order while
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

    localparam int HOLD_CYCLES = 300;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    // Heap model plus the queue of result words still owed by the block
    class heap_scoreboard;
        ffa_pkg::addr_t     heap_start;
        ffa_pkg::addr_t     heap_end;
        ffa_pkg::addr_t     top_ptr;
        ffa_pkg::addr_t     list_head;
        bit [15:0]          size_mem [ffa_pkg::SLOT_COUNT];
        bit [15:0]          link_mem [ffa_pkg::SLOT_COUNT];
        ffa_pkg::out_word_t grants_due [$];
        int                 errors;

        function new();
            heap_start = ffa_pkg::HEAP_START_RESET;
            heap_end   = ffa_pkg::HEAP_END_RESET;
            top_ptr    = ffa_pkg::HEAP_START_RESET;
            list_head  = '0;
            errors     = 0;
        endfunction

        function int unsigned slot_index(ffa_pkg::addr_t hdr);
            return (int'(hdr) / ffa_pkg::ALIGN_BYTES) % ffa_pkg::SLOT_COUNT;
        endfunction

        function void write_reg(logic [ffa_pkg::CFG_INDEX_BITS-1:0] idx,
                                ffa_pkg::addr_t data);
            if (idx == ffa_pkg::CFG_HEAP_START) begin
                heap_start = data;
                top_ptr    = data;
            end else if (idx == ffa_pkg::CFG_HEAP_END) begin
                heap_end = data;
            end
        endfunction

        // Work out the result of one accepted request and queue it
        function ffa_pkg::out_word_t note_request(ffa_pkg::in_word_t w);
            ffa_pkg::out_word_t r;
            int unsigned        need;
            int unsigned        steps;
            int unsigned        s;
            ffa_pkg::addr_t     cur;
            ffa_pkg::addr_t     prev;
            ffa_pkg::addr_t     hdr;
            bit                 at_head;
            bit                 found;
            r.addr = '0;
            r.ok   = 1'b1;
            if (w.opcode == ffa_pkg::OP_ALLOC) begin
                r.ok = 1'b0;
                need = ((int'(w.req_size) + ffa_pkg::HEADER_BYTES + ffa_pkg::ALIGN_BYTES - 1)
                        / ffa_pkg::ALIGN_BYTES) * ffa_pkg::ALIGN_BYTES;
                // rounding overflow fails without search or bump
                if (need < (1 << ffa_pkg::ADDR_BITS)) begin
                    cur     = list_head;
                    prev    = '0;
                    at_head = 1'b1;
                    found   = 1'b0;
                    steps   = 0;
                    // first fit, walk bounded in case the list loops
                    while (cur != 0 && steps < ffa_pkg::SLOT_COUNT && !found) begin
                        s = slot_index(cur);
                        if (size_mem[s] >= need) begin
                            if (at_head)
                                list_head = link_mem[s];
                            else
                                link_mem[slot_index(prev)] = link_mem[s];
                            r.addr = ffa_pkg::addr_t'(cur + ffa_pkg::HEADER_BYTES);
                            r.ok   = 1'b1;
                            found  = 1'b1;
                        end else begin
                            prev    = cur;
                            at_head = 1'b0;
                            cur     = link_mem[s];
                            steps++;
                        end
                    end
                    // bump at top; new top must stay below heap end
                    if (!found && (int'(top_ptr) + need) < int'(heap_end)) begin
                        s           = slot_index(top_ptr);
                        r.addr      = ffa_pkg::addr_t'(top_ptr + ffa_pkg::HEADER_BYTES);
                        r.ok        = 1'b1;
                        size_mem[s] = need[15:0];
                        link_mem[s] = '0;
                        top_ptr     = ffa_pkg::addr_t'(top_ptr + need);
                    end
                end
            end else if (w.free_addr != 0) begin
                // push onto list head
                hdr                       = ffa_pkg::addr_t'(w.free_addr
                                                             - ffa_pkg::HEADER_BYTES);
                link_mem[slot_index(hdr)] = list_head;
                list_head                 = hdr;
            end
            grants_due.push_back(r);
            return r;
        endfunction

        function void check_grant(ffa_pkg::out_word_t got);
            ffa_pkg::out_word_t want;
            if (grants_due.size() == 0) begin
                $display("%0t: unexpected result word addr=%h ok=%b",
                         $time, got.addr, got.ok);
                errors++;
                return;
            end
            want = grants_due.pop_front();
            if (got.addr !== want.addr) begin
                $display("%0t: addr mismatch: expected %h, actual %h",
                         $time, want.addr, got.addr);
                errors++;
            end
            if (got.ok !== want.ok) begin
                $display("%0t: ok mismatch: expected %b, actual %b",
                         $time, want.ok, got.ok);
                errors++;
            end
        endfunction
    endclass

    logic                               aclk;
    logic                               aresetn;
    logic                               s_valid;
    logic                               s_ready;
    ffa_pkg::in_word_t                  s_word;
    logic                               m_valid;
    logic                               m_ready;
    ffa_pkg::out_word_t                 m_word;
    logic                               cfg_we;
    logic [ffa_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [ffa_pkg::CFG_DATA_BITS-1:0]  cfg_wdata;

    heap_scoreboard sb;
    ffa_pkg::addr_t held_blocks [$];
    idle_mode_t     idle_mode  = IDLE_NONE;
    int unsigned    word_count = 0;
    bit             hold_req   = 1'b0;
    bit             hold_done  = 1'b0;

    first_fit_free_list_allocator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #50_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: random stalls plus one long hold-off
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end
            if (idle_mode == IDLE_RECV)
                m_ready <= ($urandom_range(0, 99) >= 48);
            else if (idle_mode == IDLE_BOTH)
                m_ready <= ($urandom_range(0, 99) >= 32);
            else
                m_ready <= 1'b1;
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_grant(m_word);
    end

    function automatic ffa_pkg::in_word_t alloc_word(ffa_pkg::addr_t size);
        ffa_pkg::in_word_t w;
        w.opcode    = ffa_pkg::OP_ALLOC;
        w.req_size  = size;
        w.free_addr = ffa_pkg::addr_t'($urandom);
        return w;
    endfunction

    function automatic ffa_pkg::in_word_t free_word(ffa_pkg::addr_t payload);
        ffa_pkg::in_word_t w;
        w.opcode    = ffa_pkg::OP_FREE;
        w.req_size  = ffa_pkg::addr_t'($urandom);
        w.free_addr = payload;
        return w;
    endfunction

    // Offer one request word, wait for acceptance, track held blocks
    task automatic send_word(input ffa_pkg::in_word_t w, output ffa_pkg::out_word_t grant);
        int unsigned k;
        idle_mode = idle_mode_t'((word_count / 75) % 4);
        word_count++;
        @(negedge aclk);
        while ((idle_mode == IDLE_SEND && $urandom_range(0, 99) < 48) ||
               (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 32)) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        grant = sb.note_request(w);
        if (w.opcode == ffa_pkg::OP_FREE) begin
            k = 0;
            while (k < held_blocks.size()) begin
                if (held_blocks[k] == w.free_addr)
                    held_blocks.delete(k);
                else
                    k++;
            end
        end else if (grant.ok) begin
            held_blocks.push_back(grant.addr);
        end
    endtask

    task automatic cfg_write(logic [ffa_pkg::CFG_INDEX_BITS-1:0] idx, ffa_pkg::addr_t data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Stop offering and wait for every owed result word
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.grants_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic run_directed();
        ffa_pkg::out_word_t g;
        ffa_pkg::out_word_t blk_a;
        ffa_pkg::out_word_t blk_b;
        ffa_pkg::out_word_t blk_c;
        ffa_pkg::out_word_t blk_d;
        cfg_write(ffa_pkg::CFG_HEAP_START, ffa_pkg::HEAP_START_RESET);
        cfg_write(ffa_pkg::CFG_HEAP_END, ffa_pkg::HEAP_END_RESET);
        send_word(alloc_word(16'd0), g);       // block with header at zero
        send_word(alloc_word(16'hFFFF), g);    // rounding overflow
        send_word(alloc_word(16'hFFFC), g);    // rounding overflow
        send_word(alloc_word(16'hFFF8), g);    // fits the range, heap full
        send_word(free_word(16'h0000), g);     // null free
        send_word(alloc_word(16'd1), blk_a);
        send_word(alloc_word(16'd12), blk_b);
        send_word(alloc_word(16'd100), blk_c);
        send_word(free_word(blk_b.addr), g);
        send_word(free_word(blk_c.addr), g);
        send_word(alloc_word(16'd50), g);      // reuse from list head
        send_word(free_word(blk_c.addr), g);
        send_word(free_word(blk_a.addr), g);
        send_word(alloc_word(16'd10), g);      // unlink past the head
        send_word(alloc_word(16'd200), g);     // nothing fits, bump
        send_word(free_word(ffa_pkg::addr_t'(ffa_pkg::HEADER_BYTES)), g);  // empties list
        send_word(alloc_word(16'd4), blk_d);
        send_word(free_word(blk_d.addr), g);
        send_word(free_word(blk_d.addr), g);   // double free, list loops on itself
        send_word(alloc_word(16'd3), g);       // fits the looping block
        send_word(alloc_word(16'd20), g);      // bounded walk, then bump
        send_word(free_word(ffa_pkg::addr_t'(ffa_pkg::HEADER_BYTES)), g);
        drain();
        held_blocks.delete();
    endtask

    function automatic ffa_pkg::in_word_t random_word();
        int unsigned    pick;
        int unsigned    r;
        ffa_pkg::addr_t size;
        pick = $urandom_range(0, 99);
        if (pick < 42 && held_blocks.size() > 0)
            return free_word(held_blocks[$urandom_range(0, held_blocks.size() - 1)]);
        if (pick < 44)
            return free_word(16'h0000);
        if (pick < 45)
            return free_word(ffa_pkg::addr_t'(ffa_pkg::HEADER_BYTES));
        r = $urandom_range(0, 99);
        if (r < 70)
            size = ffa_pkg::addr_t'($urandom_range(0, 64));
        else if (r < 92)
            size = ffa_pkg::addr_t'($urandom_range(0, 1024));
        else
            size = ffa_pkg::addr_t'($urandom);
        return alloc_word(size);
    endfunction

    // One heap setting: configure, random traffic, empty the list, drain
    task automatic run_phase(ffa_pkg::addr_t start, ffa_pkg::addr_t lim,
                             int unsigned n_words, bit with_hold);
        ffa_pkg::out_word_t g;
        cfg_write(ffa_pkg::CFG_HEAP_START, start);
        cfg_write(ffa_pkg::CFG_HEAP_END, lim);
        for (int unsigned i = 0; i < n_words; i++) begin
            if (with_hold && i == 200)
                hold_req = 1'b1;
            send_word(random_word(), g);
        end
        send_word(free_word(ffa_pkg::addr_t'(ffa_pkg::HEADER_BYTES)), g);
        drain();
        held_blocks.delete();
    endtask

    initial begin
        sb        = new();
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_word    = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        run_directed();
        run_phase(16'h0000, 16'hFFFF, 320, 1'b1);
        run_phase(16'h8001, 16'hFFFF, 300, 1'b0);
        run_phase(16'h0003, 16'h0400, 330, 1'b0);
        run_phase(16'hFFFF, 16'hFFFF, 60, 1'b0);
        run_phase(16'h1000, 16'h0000, 60, 1'b0);
        run_phase(16'h7FFE, 16'h9000, 280, 1'b0);

        if (sb.errors == 0 && sb.grants_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
